FILE: hdl/klex_pkg.sv
// ----------------------------------------------------------------------------
// klex_pkg
// Shared types and constants for the keyword, identifier and number lexer.
// ----------------------------------------------------------------------------
package klex_pkg;

  localparam int SIG_CHARS = 10;
  localparam int CNT_W     = 4;

  localparam logic [3:0] TK_INVALID = 4'd0;
  localparam logic [3:0] TK_PROGRAM = 4'd1;
  localparam logic [3:0] TK_BEGIN   = 4'd2;
  localparam logic [3:0] TK_END     = 4'd3;
  localparam logic [3:0] TK_IDENT   = 4'd4;
  localparam logic [3:0] TK_NUMBER  = 4'd5;
  localparam logic [3:0] TK_SEMI    = 4'd6;
  localparam logic [3:0] TK_PERIOD  = 4'd7;
  localparam logic [3:0] TK_EOF     = 4'd8;

  // Keyword texts packed first character in the low byte.
  localparam logic [63:0] KW_PROGRAM_TEXT = 64'h006D_6172_676F_7250;
  localparam logic [63:0] KW_BEGIN_TEXT   = 64'h0000_006E_6967_6542;
  localparam logic [63:0] KW_END_TEXT     = 64'h0000_0000_0064_6E45;
  localparam logic [3:0]  KW_PROGRAM_LEN  = 4'd7;
  localparam logic [3:0]  KW_BEGIN_LEN    = 4'd5;
  localparam logic [3:0]  KW_END_LEN      = 4'd3;

  localparam logic [30:0] MAX_VALUE = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CLS_SPACE  = 3'd0,
    CLS_LETTER = 3'd1,
    CLS_DIGIT  = 3'd2,
    CLS_SEMI   = 3'd3,
    CLS_PERIOD = 3'd4,
    CLS_OTHER  = 3'd5,
    CLS_EOI    = 3'd6
  } char_class_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } lex_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] ident_head;
    logic [15:0] ident_tail;
    logic [3:0]  ident_length;
    logic [30:0] number_value;
    logic        number_overflow;
    logic        last_of_run;
  } lex_tok_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  char_code;
  } lex_cmd_t;

endpackage

FILE: hdl/keyword_ident_number_lexer_unit.sv
// ----------------------------------------------------------------------------
// keyword_ident_number_lexer_unit
// Byte-stream scanner that turns source characters into keyword,
// identifier, number and symbol tokens.
// ----------------------------------------------------------------------------
// The input side is a queue: a source byte, or an end-of-input mark, is
// taken on a rising edge with push high and full low. The result side is a
// queue too: while empty is low the oldest token sits on the token port, and
// it leaves on a rising edge with pop high.
// A classifier with a two-entry queue feeds the scanner, and the scanner
// writes into a two-entry token queue, so each side stalls on its own.
// A byte can be taken every cycle while full is low. A byte that both ends a pending
// identifier or number and makes a token of its own stays at the head of the
// byte queue until the scanner has written both tokens, the pending one first.
// A token reaches the output by way of the byte queue, which takes the byte
// that finished it, and the token queue, into which the scanner writes it; a
// stall at either queue holds it back.
// If the receiver stops popping, the token queue
// fills, then the byte queue, and full rises; nothing is lost.
// After the end-of-input mark the eof token is the last one produced; later
// bytes are taken and dropped until reset. Reset empties both queues and
// returns the scanner to the between-tokens state.
// ----------------------------------------------------------------------------
module keyword_ident_number_lexer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  klex_pkg::lex_in_t  item,
  output logic               empty,
  input  logic               pop,
  output klex_pkg::lex_tok_t token
);
  import klex_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  lex_cmd_t cmd;

  klex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  klex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
  );

  a_accept_reaches_scanner: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> cmd_valid)
    else $error("accepted byte did not reach the scanner");

  a_reset_clears_queues: assert property (@(posedge clk)
    rst |=> empty && !full && !cmd_valid)
    else $error("queues not empty after reset");

  a_kind_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> token.token_kind <= TK_EOF)
    else $error("token kind out of range");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && token.token_kind == TK_EOF |-> token.last_of_run)
    else $error("eof token not marked last of run");

endmodule

FILE: hdl/klex_front.sv
// ----------------------------------------------------------------------------
// klex_front
// Accepts source bytes, classifies each one and holds the classified words
// in a two-entry queue for the scanner.
// ----------------------------------------------------------------------------
module klex_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  klex_pkg::lex_in_t item,
  output logic              cmd_valid,
  output klex_pkg::lex_cmd_t cmd,
  input  logic              cmd_pop
);
  import klex_pkg::*;

  lex_cmd_t    cmd_mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push_ok;
  logic        pop_ok;
  char_class_t cls_in;

  always_comb begin
    priority if (item.end_of_input) begin
      cls_in = CLS_EOI;
    end else if ((item.char_code >= 8'd9 && item.char_code <= 8'd13) ||
                 item.char_code == 8'd32) begin
      cls_in = CLS_SPACE;
    end else if ((item.char_code >= 8'd65 && item.char_code <= 8'd90) ||
                 (item.char_code >= 8'd97 && item.char_code <= 8'd122)) begin
      cls_in = CLS_LETTER;
    end else if (item.char_code >= 8'd48 && item.char_code <= 8'd57) begin
      cls_in = CLS_DIGIT;
    end else if (item.char_code == 8'd59) begin
      cls_in = CLS_SEMI;
    end else if (item.char_code == 8'd46) begin
      cls_in = CLS_PERIOD;
    end else begin
      cls_in = CLS_OTHER;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = cmd_mem[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      cmd_mem[wr_ptr] <= '{cls: cls_in, char_code: item.char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/klex_back.sv
// ----------------------------------------------------------------------------
// klex_back
// Scanner state machine: builds identifiers and numbers from classified
// bytes and writes finished tokens into a two-entry result queue.
// ----------------------------------------------------------------------------
module klex_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  klex_pkg::lex_cmd_t cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output klex_pkg::lex_tok_t token
);
  import klex_pkg::*;

  scan_mode_t       mode;
  scan_mode_t       mode_next;
  logic [7:0]       ident_store [SIG_CHARS];
  logic [CNT_W-1:0] ident_count;
  logic [30:0]      number_accum;
  logic             overflow_seen;
  logic             input_finished;

  lex_tok_t   tok_mem [2];
  logic       tok_wr_ptr;
  logic       tok_rd_ptr;
  logic [1:0] tok_count;
  logic       tok_space;

  logic        is_letter;
  logic        is_digit;
  logic        in_ident;
  logic        in_number;
  logic        pending;
  logic        continues;
  logic        starts_token;
  logic        need_tok;
  logic        step;
  logic        hold;
  logic        emit;
  lex_tok_t    tok_new;
  lex_tok_t    flush_tok;
  lex_tok_t    single_tok;
  logic [63:0] head;
  logic [15:0] tail;
  logic [3:0]  kw_kind;
  logic [3:0]  digit;
  logic [34:0] scaled;
  logic        add_ovf;
  logic        store_we;
  logic        start_ident;
  logic        start_number;
  logic        add_digit;
  logic        tok_pop_ok;

  assign is_letter = (cmd.cls == CLS_LETTER);
  assign is_digit  = (cmd.cls == CLS_DIGIT);
  assign in_ident  = (mode == MODE_IDENT);
  assign in_number = (mode == MODE_NUMBER);
  assign pending   = in_ident || in_number;
  assign continues = (in_ident && (is_letter || is_digit)) || (in_number && is_digit);
  assign starts_token = (cmd.cls == CLS_SEMI) || (cmd.cls == CLS_PERIOD) ||
                        (cmd.cls == CLS_OTHER) || (cmd.cls == CLS_EOI);

  assign need_tok = !input_finished && !continues && (pending || starts_token);
  assign tok_space = (tok_count != 2'd2);
  assign step = cmd_valid && (!need_tok || tok_space);
  assign hold = !input_finished && pending && !continues && starts_token;
  assign emit = step && need_tok;
  assign cmd_pop = step && !hold;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      head[8*i +: 8] = (ident_count > CNT_W'(i)) ? ident_store[i] : 8'h00;
    end
    for (int i = 0; i < 2; i++) begin
      tail[8*i +: 8] = (ident_count > CNT_W'(i + 8)) ? ident_store[i + 8] : 8'h00;
    end
  end

  always_comb begin
    priority if (ident_count == KW_PROGRAM_LEN && head == KW_PROGRAM_TEXT) begin
      kw_kind = TK_PROGRAM;
    end else if (ident_count == KW_BEGIN_LEN && head == KW_BEGIN_TEXT) begin
      kw_kind = TK_BEGIN;
    end else if (ident_count == KW_END_LEN && head == KW_END_TEXT) begin
      kw_kind = TK_END;
    end else begin
      kw_kind = TK_IDENT;
    end
  end

  assign digit   = cmd.char_code[3:0] - 4'd0;
  assign scaled  = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0} +
                   35'(digit);
  assign add_ovf = (scaled > 35'(MAX_VALUE));

  always_comb begin
    flush_tok = '0;
    if (in_ident) begin
      flush_tok.token_kind   = kw_kind;
      flush_tok.ident_head   = head;
      flush_tok.ident_tail   = tail;
      flush_tok.ident_length = ident_count;
    end else begin
      flush_tok.token_kind      = TK_NUMBER;
      flush_tok.number_value    = number_accum;
      flush_tok.number_overflow = overflow_seen;
    end
    flush_tok.last_of_run = !starts_token;

    single_tok = '0;
    single_tok.last_of_run = 1'b1;
    unique case (cmd.cls)
      CLS_SEMI:   single_tok.token_kind = TK_SEMI;
      CLS_PERIOD: single_tok.token_kind = TK_PERIOD;
      CLS_EOI:    single_tok.token_kind = TK_EOF;
      default:    single_tok.token_kind = TK_INVALID;
    endcase

    tok_new = pending ? flush_tok : single_tok;
  end

  always_comb begin
    mode_next    = mode;
    store_we     = 1'b0;
    start_ident  = 1'b0;
    start_number = 1'b0;
    add_digit    = 1'b0;
    if (step && !input_finished) begin
      if (continues) begin
        store_we  = in_ident && (ident_count < CNT_W'(SIG_CHARS));
        add_digit = in_number;
      end else if (!hold) begin
        start_ident  = is_letter;
        start_number = is_digit;
        mode_next    = is_letter ? MODE_IDENT : (is_digit ? MODE_NUMBER : MODE_IDLE);
      end else begin
        mode_next = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SIG_CHARS; i++) begin
      if ((store_we && ident_count == CNT_W'(i)) || (start_ident && i == 0)) begin
        ident_store[i] <= cmd.char_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      ident_count    <= '0;
      number_accum   <= '0;
      overflow_seen  <= 1'b0;
      input_finished <= 1'b0;
    end else begin
      mode <= mode_next;
      if (start_ident) begin
        ident_count <= CNT_W'(1);
      end else if (store_we) begin
        ident_count <= ident_count + CNT_W'(1);
      end
      if (start_number) begin
        number_accum  <= 31'(digit);
        overflow_seen <= 1'b0;
      end else if (add_digit) begin
        number_accum  <= add_ovf ? 31'd0 : scaled[30:0];
        overflow_seen <= overflow_seen || add_ovf;
      end
      if (emit && !hold && cmd.cls == CLS_EOI) begin
        input_finished <= 1'b1;
      end
    end
  end

  assign empty      = (tok_count == 2'd0);
  assign token      = tok_mem[tok_rd_ptr];
  assign tok_pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (emit) begin
      tok_mem[tok_wr_ptr] <= tok_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_wr_ptr <= 1'b0;
      tok_rd_ptr <= 1'b0;
      tok_count  <= 2'd0;
    end else begin
      if (emit) begin
        tok_wr_ptr <= !tok_wr_ptr;
      end
      if (tok_pop_ok) begin
        tok_rd_ptr <= !tok_rd_ptr;
      end
      unique case ({emit, tok_pop_ok})
        2'b10:   tok_count <= tok_count + 2'd1;
        2'b01:   tok_count <= tok_count - 2'd1;
        default: tok_count <= tok_count;
      endcase
    end
  end

endmodule
